[design/timeslice_tick_manager_assert.svh]
// Assertion macros for the timeslice tick manager RTL.
`ifndef TIMESLICE_TICK_MANAGER_ASSERT_SVH
`define TIMESLICE_TICK_MANAGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTM_ASSERT_IMP(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |-> (cons)) \
		else $error("timeslice tick manager: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTM_ASSERT_NXT(lbl, clk_sig, rst_n_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) (ante) |=> (cons)) \
		else $error("timeslice tick manager: next-cycle check failed");

`endif

[design/ttm_pkg.sv]
// Package with request/result types and codes for the timeslice tick manager.
`default_nettype none

package ttm_pkg;

	// Fixed field widths.
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned HANDLE_W  = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned MASK_W    = 8;
	localparam int unsigned TICKS_W   = 16;

	// Table size default and configuration reset value.
	localparam int unsigned SLOT_COUNT_DEF = 8;
	localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;

	// Request kinds.
	localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TAKE       = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RANGE      = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [HANDLE_W-1:0] handle;
		logic [HANDLE_W-1:0] pool_start;
		logic [HANDLE_W-1:0] pool_len;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    slot_index;
		logic [HANDLE_W-1:0] pending_count;
		logic [MASK_W-1:0]   switch_mask;
		logic [MASK_W-1:0]   freed_mask;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

[design/ttm_ctrl.sv]
// Controller state machine sequencing one request at a time.
`default_nettype none
`include "timeslice_tick_manager_assert.svh"

module ttm_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	output ttm_pkg::cmd_t    cmd
);
	import ttm_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	// Next-state logic: a started request enters execute, and execute always returns to idle.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands and handshake outputs.
	assign busy     = (state_q == S_EXEC);
	assign cmd.load = start && !busy;
	assign cmd.exec = (state_q == S_EXEC);
	assign done     = done_q;

	// State and result strobe registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	`TTM_ASSERT_NXT(a_load_then_exec, clk, arst_n, cmd.load, cmd.exec)
	`TTM_ASSERT_NXT(a_exec_then_done, clk, arst_n, cmd.exec, done)
	`TTM_ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)
	`TTM_ASSERT_NXT(a_busy_one_cycle, clk, arst_n, busy, !busy)

endmodule

`default_nettype wire

[design/ttm_dp.sv]
// Datapath holding the slot table, the reload register and the result register.
`default_nettype none

module ttm_dp #(
	parameter int unsigned SLOT_COUNT = ttm_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ttm_pkg::cmd_t               cmd,
	input  wire ttm_pkg::req_t               req,
	input  wire logic                        cfg_we,
	input  wire logic [ttm_pkg::TICKS_W-1:0] cfg_wdata,
	output ttm_pkg::rsp_t                    rsp
);
	import ttm_pkg::*;

	localparam int unsigned SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Slot table.
	logic                valid_q  [SLOT_COUNT];
	logic [HANDLE_W-1:0] handle_q [SLOT_COUNT];
	logic [HANDLE_W-1:0] pend_q   [SLOT_COUNT];
	logic [TICKS_W-1:0]  cd_q     [SLOT_COUNT];

	logic                valid_d  [SLOT_COUNT];
	logic [HANDLE_W-1:0] handle_d [SLOT_COUNT];
	logic [HANDLE_W-1:0] pend_d   [SLOT_COUNT];
	logic [TICKS_W-1:0]  cd_d     [SLOT_COUNT];

	logic [TICKS_W-1:0]  ticks_q;
	req_t                req_s1;
	logic [HANDLE_W:0]   range_end_s1;
	rsp_t                rsp_d;
	rsp_t                rsp_q;

	// Table update and result for the captured request.
	always_comb begin
		logic                  hit_found;
		logic [SLOT_IDX_W-1:0] hit_idx;
		logic                  free_found;
		logic [SLOT_IDX_W-1:0] free_idx;
		logic [TICKS_W-1:0]    cd_dec;

		valid_d  = valid_q;
		handle_d = handle_q;
		pend_d   = pend_q;
		cd_d     = cd_q;
		rsp_d    = '0;

		// Lowest valid slot holding the handle, and lowest free slot.
		hit_found  = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		cd_dec     = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!hit_found && valid_q[i] && (handle_q[i] == req_s1.handle)) begin
				hit_found = 1'b1;
				hit_idx   = SLOT_IDX_W'(i);
			end
			if (!free_found && !valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_IDX_W'(i);
			end
		end

		case (req_s1.req_type)
			REQ_TICK: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (valid_q[i] && (handle_q[i] != '0)) begin
						pend_d[i] = pend_q[i] + 1'b1;
						cd_dec    = (cd_q[i] != '0) ? (cd_q[i] - 1'b1) : cd_q[i];
						if (cd_dec == '0) begin
							rsp_d.switch_mask[i] = 1'b1;
							cd_d[i]              = ticks_q;
						end else begin
							cd_d[i] = cd_dec;
						end
					end
				end
			end
			REQ_REGISTER: begin
				if (free_found) begin
					valid_d[free_idx]  = 1'b1;
					handle_d[free_idx] = req_s1.handle;
					pend_d[free_idx]   = '0;
					cd_d[free_idx]     = ticks_q;
					rsp_d.slot_index   = IDX_W'(free_idx);
				end else begin
					rsp_d.status = STAT_FULL;
				end
			end
			REQ_UNREGISTER: begin
				if (hit_found) begin
					valid_d[hit_idx]           = 1'b0;
					handle_d[hit_idx]          = '0;
					rsp_d.slot_index           = IDX_W'(hit_idx);
					rsp_d.freed_mask[hit_idx]  = 1'b1;
				end else begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			REQ_TAKE: begin
				if (hit_found) begin
					rsp_d.slot_index    = IDX_W'(hit_idx);
					rsp_d.pending_count = pend_q[hit_idx];
					pend_d[hit_idx]     = '0;
				end else begin
					rsp_d.status = STAT_NOT_FOUND;
				end
			end
			REQ_RANGE: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (valid_q[i] && (handle_q[i] >= req_s1.pool_start)
						&& ({1'b0, handle_q[i]} < range_end_s1)) begin
						valid_d[i]          = 1'b0;
						handle_d[i]         = '0;
						rsp_d.freed_mask[i] = 1'b1;
					end
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// Slot table and reload register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_RESET;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				valid_q[i]  <= 1'b0;
				handle_q[i] <= '0;
				pend_q[i]   <= '0;
				cd_q[i]     <= '0;
			end
		end else begin
			if (cfg_we) begin
				ticks_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				valid_q  <= valid_d;
				handle_q <= handle_d;
				pend_q   <= pend_d;
				cd_q     <= cd_d;
			end
		end
	end

	// Request capture with the range end precomputed, and the result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1       <= req;
			range_end_s1 <= {1'b0, req.pool_start} + {1'b0, req.pool_len};
		end
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

[design/timeslice_tick_manager.sv]
// Top level of the timeslice tick manager: controller plus slot-table datapath.
//
//   channel   signals                    direction  accepted when
//   request   start, busy, req           in         start && !busy at a clock edge
//   result    done, rsp                  out        the cycle done is high
//   config    cfg_we, cfg_wdata          in         cfg_we at a clock edge
//
// Each request is first captured and then, in execute, the whole slot table is
// compared and updated in parallel. The result is shown with done in the cycle
// after execute, while a new request may already be taken. No new request is
// taken while the controller is in execute (busy high). Reset clears the table
// and loads a reload value of ten; the result side cannot stall.
`default_nettype none

module timeslice_tick_manager #(
	parameter int unsigned SLOT_COUNT = ttm_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire ttm_pkg::req_t               req,
	output logic                             done,
	output ttm_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_we,
	input  wire logic [ttm_pkg::TICKS_W-1:0] cfg_wdata
);
	import ttm_pkg::*;

	cmd_t cmd;

	ttm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ttm_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[bench/tb_timeslice_tick_manager.sv]
// Self-checking testbench for the timeslice tick manager: directed and random requests.
`timescale 1ns / 1ps

module tb_timeslice_tick_manager;

	import ttm_pkg::*;

	localparam int unsigned N_SLOTS = SLOT_COUNT_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_RANGE + 3'd1;
	localparam logic [HANDLE_W-1:0] POOL_BASE = 32'h2000_0000;
	localparam logic [HANDLE_W-1:0] POOL_STRIDE = 32'h0000_0040;
	localparam logic [HANDLE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [TICKS_W-1:0] cfg_wdata;

	// Shadow copy of the slot table and the reload register.
	logic slot_live [N_SLOTS];
	logic [HANDLE_W-1:0] slot_owner [N_SLOTS];
	logic [HANDLE_W-1:0] slot_backlog [N_SLOTS];
	logic [TICKS_W-1:0] slot_remaining [N_SLOTS];
	logic [TICKS_W-1:0] reload_value;

	rsp_t expected_results[$];
	rsp_t want;
	int sender_idle_pct;
	int error_count;
	int requests_sent;
	int results_checked;
	int full_seen;
	int not_found_seen;
	int switch_results;
	int freed_results;
	int idle_cycles;

	timeslice_tick_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Lowest live slot holding the given handle, or -1.
	function automatic int find_owner(input logic [HANDLE_W-1:0] h);
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_live[i] && slot_owner[i] == h)
				return i;
		end
		return -1;
	endfunction

	// Applies one request to the shadow table and returns the result it must produce.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int hit;
		logic [HANDLE_W:0] lo;
		logic [HANDLE_W:0] hi;
		res = '0;
		case (r.req_type)
			REQ_TICK: begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (slot_live[i] && slot_owner[i] != '0) begin
						slot_backlog[i] = slot_backlog[i] + 1'b1;
						if (slot_remaining[i] != '0)
							slot_remaining[i] = slot_remaining[i] - 1'b1;
						if (slot_remaining[i] == '0) begin
							res.switch_mask[i] = 1'b1;
							slot_remaining[i] = reload_value;
						end
					end
				end
			end
			REQ_REGISTER: begin
				res.status = STAT_FULL;
				for (int i = 0; i < N_SLOTS; i++) begin
					if (!slot_live[i] && res.status == STAT_FULL) begin
						slot_live[i] = 1'b1;
						slot_owner[i] = r.handle;
						slot_backlog[i] = '0;
						slot_remaining[i] = reload_value;
						res.status = STAT_OK;
						res.slot_index = i[IDX_W-1:0];
					end
				end
			end
			REQ_UNREGISTER, REQ_TAKE: begin
				hit = find_owner(r.handle);
				if (hit < 0) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					res.slot_index = hit[IDX_W-1:0];
					if (r.req_type == REQ_UNREGISTER) begin
						slot_live[hit] = 1'b0;
						slot_owner[hit] = '0;
						res.freed_mask[hit] = 1'b1;
					end else begin
						res.pending_count = slot_backlog[hit];
						slot_backlog[hit] = '0;
					end
				end
			end
			REQ_RANGE: begin
				// The range end is computed one bit wider so it never wraps.
				lo = {1'b0, r.pool_start};
				hi = {1'b0, r.pool_start} + {1'b0, r.pool_len};
				for (int i = 0; i < N_SLOTS; i++) begin
					if (slot_live[i] && {1'b0, slot_owner[i]} >= lo
							&& {1'b0, slot_owner[i]} < hi) begin
						slot_live[i] = 1'b0;
						slot_owner[i] = '0;
						res.freed_mask[i] = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic req_t make_req(input logic [REQ_W-1:0] kind,
			input logic [HANDLE_W-1:0] h, input logic [HANDLE_W-1:0] base,
			input logic [HANDLE_W-1:0] len);
		req_t r;
		r.req_type = kind;
		r.handle = h;
		r.pool_start = base;
		r.pool_len = len;
		return r;
	endfunction

	// Handle of a random live slot, with the given chance when there is one, else zero, a random value or a pool address.
	function automatic logic [HANDLE_W-1:0] pick_handle(input int known_pct);
		int live[$];
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_live[i])
				live.push_back(i);
		end
		if (live.size() != 0 && $urandom_range(99) < known_pct)
			return slot_owner[live[$urandom_range(live.size() - 1)]];
		if ($urandom_range(99) < 4)
			return '0;
		if ($urandom_range(99) < 25)
			return $urandom;
		return POOL_BASE + POOL_STRIDE * $urandom_range(15);
	endfunction

	// Mostly well-formed traffic on pool addresses, with some noise.
	function automatic req_t make_random_req();
		req_t r;
		int sel;
		int pick;
		r = make_req(REQ_TICK, $urandom, $urandom, $urandom);
		sel = $urandom_range(99);
		if (sel < 30) begin
			r.req_type = REQ_TICK;
		end else if (sel < 55) begin
			r.req_type = REQ_REGISTER;
			r.handle = pick_handle(15);
		end else if (sel < 67) begin
			r.req_type = REQ_UNREGISTER;
			r.handle = pick_handle(75);
		end else if (sel < 85) begin
			r.req_type = REQ_TAKE;
			r.handle = pick_handle(75);
		end else if (sel < 95) begin
			r.req_type = REQ_RANGE;
			pick = $urandom_range(9);
			if (pick < 5) begin
				r.pool_start = pick_handle(60) - $urandom_range(64);
				r.pool_len = $urandom_range(256);
			end else if (pick < 6) begin
				r.pool_len = '0;
			end else if (pick < 8) begin
				r.pool_start = ALL_ONES - $urandom_range(255);
				r.pool_len = ALL_ONES - $urandom_range(255);
			end
		end else begin
			r.req_type = REQ_FIRST_UNUSED + 3'($urandom_range(2));
		end
		return r;
	endfunction

	// Presents one request, with random idle cycles first, and waits until it is taken.
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_results.push_back(apply_request(r));
		requests_sent++;
	endtask

	// Stops issuing and waits until every expected result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the reload register with the block idle.
	task automatic write_timeslice(input logic [TICKS_W-1:0] value);
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_wdata <= TICKS_W'($urandom);
		reload_value = value;
	endtask

	// Fill the table with extreme, zero and duplicate handles, then overflow it.
	task automatic test_register_fill();
		send_request(make_req(REQ_REGISTER, ALL_ONES, '0, '0));
		send_request(make_req(REQ_REGISTER, '0, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h0000_1000, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h0000_1000, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h0000_2000, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h0000_2040, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h8000_0000, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'hFFFF_FFF8, '0, '0));
		send_request(make_req(REQ_REGISTER, 32'h0000_3000, '0, '0));
	endtask

	// Ticks with the reset reload value; the zero handle must stay untouched.
	task automatic test_tick_countdown();
		send_request(make_req(REQ_TICK, '0, '0, '0));
		send_request(make_req(REQ_TICK, ALL_ONES, ALL_ONES, ALL_ONES));
	endtask

	// Take and unregister hit the lowest matching slot; misses report not found.
	task automatic test_take_unregister();
		send_request(make_req(REQ_TAKE, 32'h0000_1000, '0, '0));
		send_request(make_req(REQ_TAKE, 32'h0000_1234, '0, '0));
		send_request(make_req(REQ_UNREGISTER, 32'h0000_1000, '0, '0));
		send_request(make_req(REQ_UNREGISTER, 32'h0000_1000, '0, '0));
		send_request(make_req(REQ_UNREGISTER, 32'h0000_5555, '0, '0));
	endtask

	// Empty range, a partial range, a range past the top of the address space, everything.
	task automatic test_range_unregister();
		send_request(make_req(REQ_RANGE, '0, 32'h0000_2000, '0));
		send_request(make_req(REQ_RANGE, '0, 32'h0000_2000, 32'h0000_0041));
		send_request(make_req(REQ_RANGE, '0, 32'hFFFF_FFF0, ALL_ONES));
		send_request(make_req(REQ_RANGE, '0, '0, ALL_ONES));
	endtask

	// Unused request kinds change nothing and return an all-zero result.
	task automatic test_unused_kinds();
		for (int k = 0; k < 3; k++)
			send_request(make_req(REQ_FIRST_UNUSED + 3'(k), $urandom, $urandom, $urandom));
	endtask

	// With a zero reload value a ticked slot asks for a switch on every tick.
	task automatic test_zero_timeslice();
		write_timeslice('0);
		send_request(make_req(REQ_REGISTER, 32'h0000_4000, '0, '0));
		send_request(make_req(REQ_TICK, '0, '0, '0));
		send_request(make_req(REQ_TICK, '0, '0, '0));
	endtask

	// One block of random traffic at a given reload value and sender idle rate.
	task automatic test_random_phase(input int count, input int idle_pct,
			input logic [TICKS_W-1:0] ticks);
		write_timeslice(ticks);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) == 0 || n == count / 2)
				drain_results();
			send_request(make_random_req());
		end
		sender_idle_pct = 0;
	endtask

	task automatic report_field(input string what, input logic [HANDLE_W-1:0] exp_val,
			input logic [HANDLE_W-1:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_val, got_val);
			error_count++;
		end
	endtask

	// Compare each result with the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, rsp);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				report_field("status", 32'(want.status), 32'(rsp.status));
				report_field("slot_index", 32'(want.slot_index), 32'(rsp.slot_index));
				report_field("pending_count", want.pending_count, rsp.pending_count);
				report_field("switch_mask", 32'(want.switch_mask), 32'(rsp.switch_mask));
				report_field("freed_mask", 32'(want.freed_mask), 32'(rsp.freed_mask));
				results_checked++;
				if (want.status == STAT_FULL)
					full_seen++;
				if (want.status == STAT_NOT_FOUND)
					not_found_seen++;
				if (want.switch_mask != '0)
					switch_results++;
				if (want.freed_mask != '0)
					freed_results++;
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no request or result accepted.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Reset, directed tests, random phases, then the final report.
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		reload_value = TICKS_RESET;
		for (int i = 0; i < N_SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_owner[i] = '0;
			slot_backlog[i] = '0;
			slot_remaining[i] = '0;
		end
		sender_idle_pct = 0;
		error_count = 0;
		requests_sent = 0;
		results_checked = 0;
		full_seen = 0;
		not_found_seen = 0;
		switch_results = 0;
		freed_results = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_fill();
		test_tick_countdown();
		test_take_unregister();
		test_range_unregister();
		test_unused_kinds();
		test_zero_timeslice();

		test_random_phase(250, 0, 16'd3);
		test_random_phase(250, 55, 16'hFFFF);
		test_random_phase(250, 0, 16'd1);
		test_random_phase(250, 20, 16'($urandom_range(2, 12)));
		test_random_phase(250, 55, TICKS_RESET);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d requests and %0d checked results over six reload settings.",
			requests_sent, results_checked);
		$display("Seen: %0d table full, %0d not found, %0d switch, %0d freed; %0d errors.",
			full_seen, not_found_seen, switch_results, freed_results, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
